>>> rtl/core/sha_pkg.sv
// SHA-256 stream hasher package: round constants, initial hash values,
// command struct between front and back, and a rotate-right helper function.
// No dependencies.
package sha_pkg;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } sha_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_ROUND,
    BK_ADD,
    BK_PAD,
    BK_EMIT
  } bk_state_t;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

endpackage

>>> rtl/core/sha_front.sv
// Front end: accepts words, clamps the byte count and drops empty non-last
// words, then pushes commands into a two-entry queue. Depends on sha_pkg.
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_data_word,
  input  logic [2:0]        in_byte_count,
  input  logic              in_last,
  output logic              q_valid,
  output sha_pkg::sha_cmd_t q_cmd,
  input  logic              q_pop
);
  import sha_pkg::*;

  sha_cmd_t  q_mem_r [2];
  logic      wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic      push;
  sha_cmd_t  cmd;

  // classify the incoming word
  always_comb begin
    cmd.data  = in_data_word;
    cmd.count = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    cmd.last  = in_last;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && (cmd.count != 3'd0 || cmd.last);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  // store payload
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cmd;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

>>> rtl/core/sha_back.sv
// Back end: packs bytes into the block, pads, runs 64 compression rounds
// one per cycle and emits the digest through an output register.
// Depends on sha_pkg.
module sha_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sha_pkg::sha_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);
  import sha_pkg::*;

  bk_state_t   state_r, state_nxt;
  logic [31:0] hash_r [8];
  logic [31:0] blk_r [16];
  logic [31:0] v_r [8];
  logic [5:0]  fill_r;
  logic [63:0] len_r;
  logic [63:0] flen_r;
  logic [5:0]  rnd_r;
  logic [2:0]  bidx_r;
  logic [2:0]  emit_r;
  logic        fin_r;
  logic [2:0]  cnt_r;
  logic [31:0] word_r;
  logic        pad_r;
  logic        tail_r;
  logic [4:0]  bsh;
  logic [31:0] t1, t2, w_new, s0, s1;

  // pop a command whenever the back end is idle
  assign q_pop = (state_r == BK_IDLE) && q_valid;

  // schedule word and round terms
  always_comb begin
    s0 = rotr(blk_r[1], 7) ^ rotr(blk_r[1], 18) ^ (blk_r[1] >> 3);
    s1 = rotr(blk_r[14], 17) ^ rotr(blk_r[14], 19) ^ (blk_r[14] >> 10);
    w_new = blk_r[0] + s0 + blk_r[9] + s1;
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + ROUND_K[rnd_r] + blk_r[0];
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // bit offset of the current byte within its block word
  assign bsh = {~fill_r[1:0], 3'b000};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (q_valid) state_nxt = BK_LOAD;
      BK_LOAD: begin
        if (cnt_r != 3'd0 && fill_r == 6'd63) state_nxt = BK_ROUND;
        else if (cnt_r <= 3'd1) state_nxt = fin_r ? BK_PAD : BK_IDLE;
      end
      BK_ROUND: if (rnd_r == 6'd63) state_nxt = BK_ADD;
      BK_ADD: begin
        if (pad_r && fin_r && fill_r == 6'd0 && bidx_r == 3'd1) state_nxt = BK_EMIT;
        else if (cnt_r != 3'd0) state_nxt = BK_LOAD;
        else if (fin_r) state_nxt = BK_PAD;
        else state_nxt = BK_IDLE;
      end
      BK_PAD:   if (fill_r == 6'd63) state_nxt = BK_ROUND;
      BK_EMIT:  if (!out_stall && emit_r == 3'd7 && out_valid) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      fill_r  <= 6'd0;
      len_r   <= 64'd0;
      pad_r   <= 1'b0;
      tail_r  <= 1'b0;
      fin_r   <= 1'b0;
      cnt_r   <= 3'd0;
      bidx_r  <= 3'd0;
      emit_r  <= 3'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) hash_r[i] <= START_HASH[i];
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        BK_IDLE: if (q_valid) begin
          word_r <= q_cmd.data;
          cnt_r  <= q_cmd.count;
          fin_r  <= q_cmd.last;
          len_r  <= len_r + {58'd0, q_cmd.count, 3'd0};
          flen_r <= len_r + {58'd0, q_cmd.count, 3'd0};
          bidx_r <= 3'd0;
        end
        BK_LOAD: if (cnt_r != 3'd0) begin
          blk_r[fill_r[5:2]][bsh +: 8] <= word_r[31:24];
          word_r <= {word_r[23:0], 8'h00};
          cnt_r  <= cnt_r - 3'd1;
          fill_r <= fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
            rnd_r <= 6'd0;
          end
        end
        BK_PAD: begin
          // zero to the end of the block when the pad byte leaves no room
          if (!pad_r) begin
            blk_r[fill_r[5:2]][bsh +: 8] <= PAD_BYTE;
            pad_r  <= 1'b1;
            tail_r <= (fill_r >= LEN_POS) && (fill_r != 6'd63);
          end else if (fill_r < LEN_POS || tail_r) begin
            blk_r[fill_r[5:2]][bsh +: 8] <= 8'h00;
            if (fill_r == 6'd63) tail_r <= 1'b0;
          end else begin
            blk_r[fill_r[5:2]][bsh +: 8] <= flen_r[63:56];
            flen_r <= {flen_r[55:0], 8'h00};
            if (fill_r == 6'd63) bidx_r <= 3'd1;
          end
          fill_r <= fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
            rnd_r <= 6'd0;
          end
        end
        BK_ROUND: begin
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) blk_r[i] <= blk_r[i + 1];
          blk_r[15] <= w_new;
          rnd_r <= rnd_r + 6'd1;
        end
        BK_ADD: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
          if (state_nxt == BK_EMIT) begin
            emit_r    <= 3'd0;
            out_valid <= 1'b1;
            out_digest_word <= hash_r[0] + v_r[0];
          end
        end
        BK_EMIT: if (!out_stall) begin
          if (emit_r == 3'd7) begin
            out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) hash_r[i] <= START_HASH[i];
            len_r  <= 64'd0;
            fill_r <= 6'd0;
            pad_r  <= 1'b0;
            tail_r <= 1'b0;
            fin_r  <= 1'b0;
            bidx_r <= 3'd0;
          end else begin
            out_digest_word <= hash_r[emit_r + 3'd1];
          end
          emit_r <= emit_r + 3'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_word_index = emit_r;
  assign out_last_word  = (emit_r == 3'd7);
endmodule

>>> rtl/core/sha256_stream_hasher.sv
// Channel | direction | ports
// in      | input     | in_valid, in_stall, in_data_word, in_byte_count, in_last
// out     | output    | out_valid, out_stall, out_digest_word, out_word_index, out_last_word
// A word is popped in the idle state, then its valid bytes load one per cycle;
// each full block then runs the 64 compression rounds and an add step. Padding
// writes one byte per cycle up to the block end, with a further block of rounds
// when the length does not fit; digest words leave one per cycle unless stalled.
// Reset is synchronous, active low, and restores the initial hash.
// A two-entry queue takes input transfers while the back end works or is stalled.
// Top level of the SHA-256 stream hasher; depends on sha_pkg, sha_front, sha_back.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  logic     q_valid, q_pop;
  sha_cmd_t q_cmd;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_word, .in_byte_count, .in_last,
    .q_valid, .q_cmd, .q_pop
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );

`ifndef SYNTH
  // last flag only on the final digest word
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word out of place");
  // digest words advance in order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=> out_valid &&
      out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest order broken");
  // no pop from an empty queue
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue underflow");
`endif
endmodule
